// ----- rtl/core/slsam_pkg.sv -----
// Package for the standard-linear-solid attenuation block.
// Holds field widths, register indexes, the sequencer state type and
// fixed-point helpers; it depends on nothing else.
package slsam_pkg;

    localparam int unsigned NUM_POINTS_DEF = 1024;
    localparam int unsigned MAX_SLS_DEF    = 4;

    localparam int unsigned NUM_COMP      = 6;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned COEF_W        = 20;
    localparam int unsigned POINT_W       = 10;
    localparam int unsigned SLS_CNT_W     = 3;
    localparam int unsigned NUM_COEF_REGS = 4;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 60;
    localparam int unsigned S_TDATA_W     = 272;
    localparam int unsigned M_TDATA_W     = 192;
    localparam int unsigned DIV_W         = 35;
    // The biased trace is split at this bit for the two divide-by-three steps.
    localparam int unsigned DIV_LO_W      = 17;
    localparam int unsigned RECIP3_SH     = 21;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SLS_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF3     = 3'd5;

    localparam logic [SLS_CNT_W-1:0] SLS_COUNT_RST = 3'd3;

    typedef logic signed [63:0] wide_t;
    typedef logic signed [31:0] word_t;

    // The mean is floor((sum + 1) / 3). The sum is made non-negative by
    // adding 3 * 2^33 before dividing; 2^33 is removed from the quotient.
    localparam wide_t DIV_OFFSET = 64'sh0000_0006_0000_0000;
    localparam wide_t MEAN_BIAS  = 64'sh0000_0002_0000_0000;

    // ceil(2^21 / 3): exact floor division by three for inputs below 2^21.
    localparam word_t RECIP3 = 32'sd699051;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_A_INIT,
        ST_A_RD,
        ST_A_ACC,
        ST_A_DONE,
        ST_OUT,
        ST_U_RRD,
        ST_U_RLD,
        ST_U_SUM,
        ST_U_DIV,
        ST_U_MEAN,
        ST_U_OP,
        ST_U_MUL,
        ST_U_FIN,
        ST_U_RWR,
        ST_M_RD,
        ST_M_A,
        ST_M_B,
        ST_M_C,
        ST_M_D
    } state_t;

    function automatic word_t sat32(wide_t v);
        word_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // Round half up, then drop sh fraction bits.
    function automatic wide_t rnd_shift(wide_t v, int unsigned sh);
        wide_t half;
        half = 64'sd1 <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic word_t coef_ext(logic [COEF_W-1:0] c);
        return {{(DATA_W - COEF_W){c[COEF_W-1]}}, c};
    endfunction

endpackage

// ----- rtl/core/slsam_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// Used for every on-chip store of the attenuation block; no dependencies.
module slsam_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/sls_attenuation_memory_update_top.sv -----
// Top level of the standard-linear-solid attenuation block.
// Depends on slsam_pkg and instantiates slsam_ram for both stores.
//
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tuser = func, s_tdata = point, deltas, comp0..5
// m_        out        m_tvalid / m_tready  m_tdata = out0..out5 (apply transactions only)
// cfg_      in         cfg_wr_en            cfg_addr = register index, cfg_wdata = value
//
// After reset the block runs a clearing pass that zeroes every word of both
// stores; s_tready stays low meanwhile. One transaction is worked at a time
// through a single multiplier under a small sequencer; the memory-variable
// RAM port (one word per access) sets the pace. A point index at or beyond
// NUM_POINTS is brought into range by subtracting NUM_POINTS before the work
// starts. A finished apply result sits in the output register until taken;
// the sequencer waits only if the previous result is still held when the
// next one is ready.
module sls_attenuation_memory_update_top #(
    parameter int unsigned NUM_POINTS = slsam_pkg::NUM_POINTS_DEF,
    parameter int unsigned MAX_SLS    = slsam_pkg::MAX_SLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tuser: func
    input  logic                               s_tuser,
    // tdata: point, shear_delta, bulk_delta, comp0 .. comp5, zero pad
    input  logic [slsam_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: out0 .. out5
    output logic [slsam_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic [slsam_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [slsam_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import slsam_pkg::*;

    localparam int unsigned RS_DEPTH = NUM_POINTS * NUM_COMP;
    localparam int unsigned MV_DEPTH = NUM_POINTS * MAX_SLS * NUM_COMP;
    localparam int unsigned RS_AW    = $clog2(RS_DEPTH);
    localparam int unsigned MV_AW    = $clog2(MV_DEPTH);
    localparam int unsigned SLS_W    = $clog2(MAX_SLS + 1);
    localparam logic [2:0]  LAST_C   = 3'(NUM_COMP - 1);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SLS_CNT_W-1:0]  sls_count_reg;
    logic                  bulk_on_reg;
    logic [CFG_DATA_W-1:0] coeff_reg [NUM_COEF_REGS];

    // Captured transaction.
    logic                  func_reg;
    logic [POINT_W-1:0]    p_reg;
    word_t                 dmu_reg, dkappa_reg;
    word_t                 e_reg [NUM_COMP];

    logic [MV_AW-1:0]      mv_base_reg, clr_reg;
    logic [RS_AW-1:0]      rs_base_reg;
    logic [2:0]            c_reg, k_reg;
    logic [SLS_W-1:0]      s_reg;

    wide_t                 acc_reg, prod_reg, iso_reg;
    word_t                 rold_reg [NUM_COMP];
    word_t                 rnew_reg [NUM_COMP];
    word_t                 res_reg  [NUM_COMP];
    word_t                 op_reg, mtmp_reg, mean_reg;
    logic [DIV_W-1:0]      div_n_reg;
    logic [1:0]            div_cnt_reg;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  out_reg;

    // Control and RAM signals.
    logic [SLS_W-1:0]      n_act;
    logic                  last_c, last_s, out_free;
    logic [CFG_DATA_W-1:0] coeff_sel;
    word_t                 alpha, beta, gamma_c;
    word_t                 mul_a, mul_b;
    logic [MV_AW-1:0]      mv_addr;
    logic [RS_AW-1:0]      rs_addr;
    logic                  mv_we, rs_we;
    logic [MV_AW-1:0]      mv_waddr;
    logic [RS_AW-1:0]      rs_waddr;
    word_t                 mv_wdata, rs_wdata;
    logic [DATA_W-1:0]     mv_rdata, rs_rdata;
    logic [DIV_W-DIV_LO_W-1:0] div_hi;
    logic [1:0]            div_r;
    word_t                 div_x;
    wide_t                 dev;

    // Counts above MAX_SLS act as MAX_SLS.
    assign n_act = (32'(sls_count_reg) > MAX_SLS) ? SLS_W'(MAX_SLS)
                                                  : SLS_W'(sls_count_reg);
    assign last_c   = (c_reg == LAST_C);
    assign last_s   = (s_reg == n_act - SLS_W'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    // Solids without a coefficient register use zero coefficients.
    always_comb begin
        coeff_sel = '0;
        for (int j = 0; j < NUM_COEF_REGS; j++) begin
            if (32'(s_reg) == j) begin
                coeff_sel = coeff_reg[j];
            end
        end
    end

    assign alpha   = coef_ext(coeff_sel[COEF_W-1:0]);
    assign beta    = coef_ext(coeff_sel[2*COEF_W-1:COEF_W]);
    assign gamma_c = coef_ext(coeff_sel[3*COEF_W-1:2*COEF_W]);

    assign mv_addr = mv_base_reg + MV_AW'(32'(s_reg) * NUM_COMP + 32'(c_reg));
    assign rs_addr = rs_base_reg + RS_AW'(c_reg);

    // The biased sum is divided by three in two halves through the shared
    // multiplier: first the upper bits, then the remainder joined to the
    // lower bits. mean_reg holds the upper quotient in between.
    assign div_hi = div_n_reg[DIV_W-1:DIV_LO_W];
    assign div_r  = 2'(div_hi - ({1'b0, mean_reg[DIV_LO_W-1:0]}
                                 + {mean_reg[DIV_LO_W-1:0], 1'b0}));
    assign div_x  = {{(DATA_W - DIV_LO_W - 2){1'b0}}, div_r, div_n_reg[DIV_LO_W-1:0]};
    assign dev    = rnd_shift(prod_reg, 16) <<< 1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == MV_AW'(MV_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_WRAP;
            ST_WRAP: begin
                if (32'(p_reg) < NUM_POINTS) begin
                    state_next = func_reg ? ST_U_RRD : ST_A_INIT;
                end
            end
            ST_A_INIT: state_next = (n_act == '0) ? ST_A_DONE : ST_A_RD;
            ST_A_RD:   state_next = ST_A_ACC;
            ST_A_ACC:  state_next = last_s ? ST_A_DONE : ST_A_RD;
            ST_A_DONE: state_next = last_c ? ST_OUT : ST_A_INIT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            ST_U_RRD:  state_next = ST_U_RLD;
            ST_U_RLD:  state_next = last_c ? ST_U_SUM : ST_U_RRD;
            ST_U_SUM:  state_next = ST_U_DIV;
            ST_U_DIV:  if (div_cnt_reg == 2'd2) state_next = ST_U_MEAN;
            ST_U_MEAN: state_next = ST_U_OP;
            ST_U_OP:   state_next = ST_U_MUL;
            ST_U_MUL:  state_next = ST_U_FIN;
            ST_U_FIN:  state_next = (k_reg == 3'd6) ? ST_U_RWR : ST_U_OP;
            ST_U_RWR: begin
                if (last_c) begin
                    state_next = (n_act == '0) ? ST_IDLE : ST_M_RD;
                end
            end
            ST_M_RD:   state_next = ST_M_A;
            ST_M_A:    state_next = ST_M_B;
            ST_M_B:    state_next = ST_M_C;
            ST_M_C:    state_next = ST_M_D;
            ST_M_D:    state_next = (last_c && last_s) ? ST_IDLE : ST_M_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM ports and multiplier operands.
    always_comb begin
        mv_we    = 1'b0;
        mv_waddr = mv_addr;
        mv_wdata = sat32(wide_t'(mtmp_reg) + rnd_shift(prod_reg, 18));
        rs_we    = 1'b0;
        rs_waddr = rs_addr;
        rs_wdata = rnew_reg[c_reg];
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_CLEAR: begin
                mv_we    = 1'b1;
                mv_waddr = clr_reg;
                mv_wdata = '0;
                rs_we    = (32'(clr_reg) < RS_DEPTH);
                rs_waddr = clr_reg[RS_AW-1:0];
                rs_wdata = '0;
            end
            ST_U_DIV: begin
                if (div_cnt_reg == 2'd0) begin
                    mul_a = {{(DATA_W - (DIV_W - DIV_LO_W)){1'b0}}, div_hi};
                    mul_b = RECIP3;
                end else if (div_cnt_reg == 2'd2) begin
                    mul_a = div_x;
                    mul_b = RECIP3;
                end
            end
            ST_U_MUL: begin
                mul_a = (k_reg == 3'd0) ? dkappa_reg : dmu_reg;
                mul_b = op_reg;
            end
            ST_U_RWR: rs_we = 1'b1;
            ST_M_A: begin
                mul_a = alpha;
                mul_b = mv_rdata;
            end
            ST_M_B: begin
                mul_a = beta;
                mul_b = rold_reg[c_reg];
            end
            ST_M_C: begin
                mul_a = gamma_c;
                mul_b = rnew_reg[c_reg];
            end
            ST_M_D:   mv_we = 1'b1;
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            c_reg         <= '0;
            s_reg         <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            sls_count_reg <= SLS_COUNT_RST;
            bulk_on_reg   <= 1'b1;
            for (int j = 0; j < NUM_COEF_REGS; j++) begin
                coeff_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SLS_COUNT: sls_count_reg <= cfg_wdata[SLS_CNT_W-1:0];
                    CFG_BULK_ON:   bulk_on_reg   <= cfg_wdata[0];
                    CFG_COEF0:     coeff_reg[0]  <= cfg_wdata;
                    CFG_COEF1:     coeff_reg[1]  <= cfg_wdata;
                    CFG_COEF2:     coeff_reg[2]  <= cfg_wdata;
                    CFG_COEF3:     coeff_reg[3]  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:  clr_reg <= clr_reg + MV_AW'(1);
                ST_WRAP: begin
                    c_reg <= '0;
                    s_reg <= '0;
                end
                ST_A_INIT: s_reg <= '0;
                ST_A_ACC:  s_reg <= s_reg + SLS_W'(1);
                ST_A_DONE, ST_U_RLD, ST_U_RWR: c_reg <= last_c ? 3'd0 : c_reg + 3'd1;
                ST_U_SUM:  div_cnt_reg <= '0;
                ST_U_DIV:  div_cnt_reg <= div_cnt_reg + 2'd1;
                ST_U_MEAN: k_reg <= '0;
                ST_U_FIN:  k_reg <= k_reg + 3'd1;
                ST_M_D: begin
                    if (last_c) begin
                        c_reg <= '0;
                        s_reg <= s_reg + SLS_W'(1);
                    end else begin
                        c_reg <= c_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= wide_t'(mul_a) * wide_t'(mul_b);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_reg   <= s_tuser;
                    p_reg      <= s_tdata[9:0];
                    dmu_reg    <= s_tdata[41:10];
                    dkappa_reg <= s_tdata[73:42];
                    for (int j = 0; j < NUM_COMP; j++) begin
                        e_reg[j] <= s_tdata[74 + 32*j +: 32];
                    end
                end
            end
            ST_WRAP: begin
                if (32'(p_reg) >= NUM_POINTS) begin
                    p_reg <= p_reg - POINT_W'(NUM_POINTS);
                end
                mv_base_reg <= MV_AW'(32'(p_reg) * (MAX_SLS * NUM_COMP));
                rs_base_reg <= RS_AW'(32'(p_reg) * NUM_COMP);
            end
            ST_A_INIT: acc_reg <= wide_t'(e_reg[c_reg]);
            ST_A_ACC:  acc_reg <= acc_reg - wide_t'(signed'(mv_rdata));
            ST_A_DONE: res_reg[c_reg] <= sat32(acc_reg);
            ST_OUT: begin
                if (out_free) begin
                    for (int j = 0; j < NUM_COMP; j++) begin
                        out_reg[32*j +: 32] <= res_reg[j];
                    end
                end
            end
            ST_U_RLD:  rold_reg[c_reg] <= rs_rdata;
            ST_U_SUM: begin
                div_n_reg <= DIV_W'(wide_t'(e_reg[0]) + wide_t'(e_reg[1])
                                    + wide_t'(e_reg[2]) + 64'sd1 + DIV_OFFSET);
            end
            ST_U_DIV: begin
                if (div_cnt_reg == 2'd1) begin
                    mean_reg <= 32'(prod_reg >>> RECIP3_SH);
                end
            end
            ST_U_MEAN: begin
                mean_reg <= 32'((wide_t'(mean_reg) <<< DIV_LO_W)
                                + (prod_reg >>> RECIP3_SH) - MEAN_BIAS);
            end
            ST_U_OP: begin
                if (k_reg == 3'd0) begin
                    op_reg <= mean_reg;
                end else if (k_reg <= 3'd3) begin
                    op_reg <= sat32(wide_t'(e_reg[k_reg - 3'd1]) - wide_t'(mean_reg));
                end else begin
                    op_reg <= e_reg[k_reg - 3'd1];
                end
            end
            ST_U_FIN: begin
                if (k_reg == 3'd0) begin
                    iso_reg <= rnd_shift(prod_reg, 16) * 64'sd3;
                end else if (k_reg <= 3'd3) begin
                    if (bulk_on_reg) begin
                        rnew_reg[k_reg - 3'd1] <= sat32(iso_reg + dev);
                    end else if (k_reg == 3'd3) begin
                        // Deviatoric only: the third diagonal closes the trace.
                        rnew_reg[2] <= sat32(-(wide_t'(rnew_reg[0]) + wide_t'(rnew_reg[1])));
                    end else begin
                        rnew_reg[k_reg - 3'd1] <= sat32(dev);
                    end
                end else begin
                    rnew_reg[k_reg - 3'd1] <= sat32(rnd_shift(prod_reg, 16));
                end
            end
            ST_M_B:    acc_reg  <= prod_reg;
            ST_M_C:    mtmp_reg <= sat32(rnd_shift(acc_reg + prod_reg, 18));
            default: begin
            end
        endcase
    end

    slsam_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MV_DEPTH)
    ) u_mv_ram (
        .clk  (aclk),
        .we   (mv_we),
        .waddr(mv_waddr),
        .wdata(mv_wdata),
        .raddr(mv_addr),
        .rdata(mv_rdata)
    );

    slsam_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RS_DEPTH)
    ) u_rs_ram (
        .clk  (aclk),
        .we   (rs_we),
        .waddr(rs_waddr),
        .wdata(rs_wdata),
        .raddr(rs_addr),
        .rdata(rs_rdata)
    );

    // No transaction is taken while the stores are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // A result appears only when the apply sequence hands it over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    // The solid counter stays within the active solids in both loops.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_RD || state_reg == ST_A_RD) |-> (s_reg < n_act))
        else $error("solid index beyond active count");

    // Memory variables are written only in the clearing pass or the update loop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mv_we |-> (state_reg == ST_CLEAR || state_reg == ST_M_D))
        else $error("unexpected memory-variable write");

endmodule

// ----- tb/sv/slsam_checker.sv -----
// Checker for the standard-linear-solid attenuation block.
// Watches the input and result channels, keeps a shadow of the stores and
// registers, predicts apply results and compares them; depends on slsam_pkg.
`timescale 1ns / 100ps

module slsam_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tuser,
    input  logic [slsam_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [slsam_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [slsam_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [slsam_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                  fail_count,
    output int                                  stress_pending
);
    import slsam_pkg::*;

    localparam int NPTS = 1024;
    localparam int NSLS = 4;

    logic [2:0]  solid_count;
    logic        bulk_on;
    logic [59:0] coef_reg [NSLS];
    logic signed [31:0] mem_var [NPTS][NSLS][6];
    logic signed [31:0] relaxed [NPTS][6];
    logic [M_TDATA_W-1:0] stress_q [$];

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && (a % b) < 0) q--;
        return q;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return floor_div(v + (longint'(1) <<< (sh - 1)), longint'(1) <<< sh);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint coef_of(int s, int which);
        logic signed [19:0] c;
        c = coef_reg[s][20*which +: 20];
        return longint'(c);
    endfunction

    // Advances the shadow state for one input transaction; apply transactions
    // push their expected stress onto the queue.
    task automatic attenuate(logic op, logic [S_TDATA_W-1:0] d);
        int p, n;
        longint dmu, dk, acc, mean, iso;
        longint strain [6];
        longint dev [3];
        logic [M_TDATA_W-1:0] res;
        p = d[9:0];
        dmu = longint'($signed(d[41:10]));
        dk = longint'($signed(d[73:42]));
        for (int c = 0; c < 6; c++) strain[c] = longint'($signed(d[74+32*c +: 32]));
        n = (solid_count > NSLS) ? NSLS : solid_count;
        if (op == 1'b0) begin
            for (int c = 0; c < 6; c++) begin
                acc = strain[c];
                for (int s = 0; s < n; s++) acc -= mem_var[p][s][c];
                res[32*c +: 32] = clamp32(acc);
            end
            stress_q.push_back(res);
        end else begin
            for (int s = 0; s < n; s++)
                for (int c = 0; c < 6; c++)
                    mem_var[p][s][c] = clamp32(round_shift(coef_of(s, 0) * mem_var[p][s][c]
                        + coef_of(s, 1) * relaxed[p][c], 18));
            mean = floor_div(2 * (strain[0] + strain[1] + strain[2]) + 3, 6);
            for (int i = 0; i < 3; i++)
                dev[i] = 2 * round_shift(dmu * longint'(clamp32(strain[i] - mean)), 16);
            if (bulk_on) begin
                iso = 3 * round_shift(dk * mean, 16);
                for (int i = 0; i < 3; i++) relaxed[p][i] = clamp32(iso + dev[i]);
            end else begin
                relaxed[p][0] = clamp32(dev[0]);
                relaxed[p][1] = clamp32(dev[1]);
                relaxed[p][2] = clamp32(-(longint'(relaxed[p][0]) + relaxed[p][1]));
            end
            for (int i = 3; i < 6; i++) relaxed[p][i] = clamp32(round_shift(dmu * strain[i], 16));
            for (int s = 0; s < n; s++)
                for (int c = 0; c < 6; c++)
                    mem_var[p][s][c] = clamp32(longint'(mem_var[p][s][c])
                        + round_shift(coef_of(s, 2) * relaxed[p][c], 18));
        end
    endtask

    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            solid_count <= SLS_COUNT_RST;
            bulk_on <= 1'b1;
            for (int s = 0; s < NSLS; s++) coef_reg[s] <= '0;
            for (int p = 0; p < NPTS; p++)
                for (int c = 0; c < 6; c++) begin
                    relaxed[p][c] = '0;
                    for (int s = 0; s < NSLS; s++) mem_var[p][s][c] = '0;
                end
            stress_q.delete();
            fail_count <= 0;
            stress_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SLS_COUNT: solid_count <= cfg_wdata[2:0];
                    CFG_BULK_ON:   bulk_on <= cfg_wdata[0];
                    CFG_COEF0:     coef_reg[0] <= cfg_wdata;
                    CFG_COEF1:     coef_reg[1] <= cfg_wdata;
                    CFG_COEF2:     coef_reg[2] <= cfg_wdata;
                    CFG_COEF3:     coef_reg[3] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (stress_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    errs++;
                end else begin
                    want = stress_q.pop_front();
                    for (int c = 0; c < 6; c++)
                        if (m_tdata[32*c +: 32] !== want[32*c +: 32]) begin
                            $display("%0t: out%0d mismatch, expected %h, actual %h",
                                     $time, c, want[32*c +: 32], m_tdata[32*c +: 32]);
                            errs++;
                        end
                end
            end
            if (s_tvalid && s_tready) attenuate(s_tuser, s_tdata);
            fail_count <= fail_count + errs;
            stress_pending <= stress_q.size();
        end
    end
endmodule

// ----- tb/sv/tb_sls_attenuation_memory_update_top.sv -----
// Testbench top for the standard-linear-solid attenuation block.
// Drives apply and update transactions and register writes, and takes the
// verdict from slsam_checker; depends on slsam_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_sls_attenuation_memory_update_top;
    import slsam_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tuser = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int fail_count;
    int stress_pending;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    longint cycle_count = 0;

    always #2 aclk = ~aclk;

    sls_attenuation_memory_update_top DUT (.*);
    slsam_checker u_checker (.*);

    // The receiver stalls at random; its probability changes by phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: this limit lies far above the length of any correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Writes one register; the block is known to be idle when this runs.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Presents one transaction and holds it until the block accepts it. The
    // valid stays high across back-to-back transactions; an idle gap lowers it.
    task automatic send_item(logic op, logic [9:0] pt, logic [31:0] dmu, logic [31:0] dk,
                             logic [191:0] comps);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, comps, dk, dmu, pt};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (stress_pending != 0) @(posedge aclk);
        // Updates return nothing, so one may still be running; wait it out.
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [59:0] rand_coef();
        logic [59:0] c;
        for (int k = 0; k < 3; k++)
            c[20*k +: 20] = ($urandom_range(3) == 0) ? 20'($urandom) :
                            20'($urandom_range(262144) - 131072);
        return c;
    endfunction

    task automatic random_item(int hot_points);
        logic [191:0] comps;
        logic [9:0] pt;
        for (int c = 0; c < 6; c++) comps[32*c +: 32] = rand_word();
        // Most transactions touch a handful of points so state builds up.
        pt = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(hot_points - 1));
        send_item(1'($urandom_range(1)), pt, rand_word(), rand_word(), comps);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes of the fields with reset settings, a solid
        // count of zero and of seven (above the maximum), and the unused index.
        send_item(1'b0, 10'd0, 32'h0, 32'h0, {6{32'h7FFF_FFFF}});
        send_item(1'b1, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, {6{32'h7FFF_FFFF}});
        send_item(1'b0, 10'd1023, 32'h0, 32'h0, {6{32'h8000_0000}});
        drain_results();
        write_reg(CFG_COEF0, {20'h7FFFF, 20'h80000, 20'h40000});
        write_reg(CFG_COEF1, {20'h80000, 20'h7FFFF, 20'h00001});
        write_reg(CFG_COEF2, 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_COEF3, {20'h20000, 20'h10000, 20'h08000});
        write_reg(3'd7, 60'h5);
        for (int k = 0; k < 3; k++) begin
            send_item(1'b1, 10'd5, 32'h0001_0000, 32'h7FFF_FFFF, {6{32'h8000_0000}});
            send_item(1'b1, 10'd5, 32'h8000_0000, 32'hFFFF_0000,
                      {32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h3});
            send_item(1'b0, 10'd5, 32'h0, 32'h0, {32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0, 32'h1, 32'hFFFF_FFFF});
        end
        drain_results();
        write_reg(CFG_BULK_ON, 60'h0);
        write_reg(CFG_SLS_COUNT, 60'h7);
        send_item(1'b1, 10'd5, 32'h0002_0000, 32'h1234_5678, {6{32'h0003_0000}});
        send_item(1'b0, 10'd5, 32'h0, 32'h0, {6{32'h0}});
        drain_results();
        write_reg(CFG_SLS_COUNT, 60'h0);
        send_item(1'b1, 10'd5, 32'h0002_0000, 32'h0, {6{32'h0001_0000}});
        send_item(1'b0, 10'd5, 32'h0, 32'h0, {6{32'h0005_0000}});
        drain_results();

        // Random part in six phases, each with its own settings; phases with a
        // slow receiver cover the pressure case; each phase ends by draining.
        for (int ph = 0; ph < 6; ph++) begin
            sender_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 69 : 0;
            receiver_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 10 : 0;
            write_reg(CFG_SLS_COUNT, (ph == 0) ? 60'd1 : (ph == 5) ? 60'd4 :
                      60'($urandom_range(7)));
            write_reg(CFG_BULK_ON, 60'(ph % 2));
            for (int s = 0; s < 4; s++) write_reg(CFG_IDX_W'(CFG_COEF0 + s), rand_coef());
            for (int i = 0; i < 300; i++) random_item(8);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/slsam_pkg.sv
rtl/core/slsam_ram.sv
rtl/core/sls_attenuation_memory_update_top.sv
tb/sv/slsam_checker.sv
tb/sv/tb_sls_attenuation_memory_update_top.sv
